// ===== hw/rtl/skfl_pkg.sv =====
// Sort-key field locator: shared types, constants and tracker functions.
// Used by skfl_front, skfl_queue, skfl_back and sort_key_field_locator.
package skfl_pkg;

  localparam int LINE_LIMIT = 65535;
  localparam int POS_W      = $clog2(LINE_LIMIT + 1);
  localparam int SUM_W      = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam int LEFT_W     = 17;
  localparam int OUT_MAX    = 65535;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEPARATOR   = 3'd0,
    REG_START_FIELD = 3'd1,
    REG_START_CHAR  = 3'd2,
    REG_START_SKIP  = 3'd3,
    REG_END_FIELD   = 3'd4,
    REG_END_CHAR    = 3'd5,
    REG_END_SKIP    = 3'd6,
    REG_END_OPEN    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_OUT  = 4'b0001,
    PH_IN   = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [8:0]  separator;
    logic [15:0] start_field;
    logic [15:0] start_char;
    logic        start_skip_blanks;
    logic [15:0] end_field;
    logic [15:0] end_char;
    logic        end_skip_blanks;
    logic        end_open;
  } cfg_t;

  typedef struct packed {
    logic             eol;
    logic             line_first;
    logic             blank;
    logic             sep_hit;
    logic             sep_mode;
    logic             ovf;
    logic [POS_W-1:0] pos;
  } q_entry_t;

  typedef struct packed {
    logic [LEFT_W-1:0] left;
    phase_t            phase;
    logic [POS_W-1:0]  anchor;
  } trk_t;

  typedef struct packed {
    logic        too_long;
    logic [15:0] key_limit;
    logic [15:0] key_start;
  } res_t;

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A);
  endfunction

  function automatic trk_t trk_load(logic [LEFT_W-1:0] fields, logic skip);
    trk_t t;
    t.left   = fields;
    t.anchor = '0;
    if (fields != '0) begin
      t.phase = PH_OUT;
    end else begin
      t.phase = skip ? PH_SKIP : PH_DONE;
    end
    return t;
  endfunction

  function automatic logic trk_counting(trk_t t);
    return (t.phase == PH_OUT) || (t.phase == PH_IN);
  endfunction

  function automatic trk_t trk_step(trk_t t, q_entry_t e, logic skip, logic take_last);
    trk_t              n;
    logic [LEFT_W-1:0] dec;
    logic [POS_W-1:0]  pos_inc;
    n       = t;
    dec     = t.left - LEFT_W'(1);
    pos_inc = e.pos + POS_W'(1);
    unique case (t.phase)
      PH_OUT, PH_IN: begin
        if (e.sep_mode) begin
          if (e.sep_hit) begin
            n.left = dec;
            if (dec == '0) begin
              if (take_last) begin
                n.anchor = pos_inc;
                n.phase  = skip ? PH_SKIP : PH_DONE;
              end else begin
                n.anchor = e.pos;
                n.phase  = PH_DONE;
              end
            end
          end
        end else if (!e.blank) begin
          n.phase = PH_IN;
        end else if (t.phase == PH_IN) begin
          n.phase = PH_OUT;
          n.left  = dec;
          if (dec == '0) begin
            if (skip) begin
              // the closing blank is itself the first skipped one
              n.anchor = pos_inc;
              n.phase  = PH_SKIP;
            end else begin
              n.anchor = e.pos;
              n.phase  = PH_DONE;
            end
          end
        end
      end
      PH_SKIP: begin
        if (e.blank) begin
          n.anchor = pos_inc;
        end else begin
          n.anchor = e.pos;
          n.phase  = PH_DONE;
        end
      end
      PH_DONE: begin
        n = t;
      end
      default: begin
        n = t;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/skfl_queue.sv =====
// Sort-key field locator: short request queue between front and back.
// Depends on skfl_pkg.
module skfl_queue
  import skfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/skfl_front.sv =====
// Sort-key field locator: input side. Takes requests, counts line position,
// drops bytes past the line limit and classifies each byte. Depends on skfl_pkg.
module skfl_front
  import skfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_byte,
  input  logic [8:0] cfg_separator,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_data
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             first_r, first_nxt;
  logic [8:0]       sep_r, sep_nxt;
  logic [8:0]       sep_cur;
  logic             accept;
  logic             at_limit;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign at_limit = (pos_r >= POS_W'(LINE_LIMIT));
  assign sep_cur  = first_r ? cfg_separator : sep_r;

  always_comb begin
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    first_nxt = first_r;
    sep_nxt   = sep_r;
    q_push    = 1'b0;

    q_data.eol        = in_func;
    q_data.line_first = first_r;
    q_data.blank      = is_blank(in_byte);
    q_data.sep_mode   = !sep_cur[8];
    q_data.sep_hit    = !sep_cur[8] && (in_byte == sep_cur[7:0]);
    q_data.ovf        = in_func && ovf_r;
    q_data.pos        = pos_r;

    if (accept) begin
      first_nxt = 1'b0;
      if (first_r) begin
        sep_nxt = cfg_separator;
      end
      if (in_func) begin
        q_push    = 1'b1;
        pos_nxt   = '0;
        ovf_nxt   = 1'b0;
        first_nxt = 1'b1;
      end else if (at_limit) begin
        ovf_nxt = 1'b1;
      end else begin
        q_push  = 1'b1;
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ovf_r   <= 1'b0;
      first_r <= 1'b1;
      sep_r   <= 9'h100;
    end else begin
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
      first_r <= first_nxt;
      sep_r   <= sep_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LINE_LIMIT))
    else $error("line position beyond limit");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (pos_r == POS_W'(LINE_LIMIT)))
    else $error("overflow without full line");

  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (pos_r == '0) && !ovf_r)
    else $error("line start with stale position");

endmodule

// ===== hw/rtl/skfl_back.sv =====
// Sort-key field locator: back end. Runs the start and end trackers on queued
// bytes and computes the key offsets at end of line. Depends on skfl_pkg.
module skfl_back
  import skfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_data
);

  cfg_t             act_r, act_nxt, act_cur;
  trk_t             st_r, st_nxt, st_cur;
  trk_t             en_r, en_nxt, en_cur;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_data_r, out_data_nxt;
  logic             etake, eskip;
  logic [LEFT_W-1:0] ef;
  logic [POS_W-1:0] len, s_base, e_base;
  logic [SUM_W-1:0] s_sum, e_sum, s_cl, e_cl, len_w;
  logic             s_sat, e_sat;

  assign act_cur = q_head.line_first ? cfg : act_r;
  assign etake   = (act_cur.end_char != '0);
  assign eskip   = act_cur.end_skip_blanks && etake;
  assign ef      = LEFT_W'(act_cur.end_field) + LEFT_W'(!etake);
  assign st_cur  = q_head.line_first ?
                   trk_load(LEFT_W'(act_cur.start_field), act_cur.start_skip_blanks) : st_r;
  assign en_cur  = q_head.line_first ? trk_load(ef, eskip) : en_r;

  assign q_pop   = q_valid && (!q_head.eol || !out_valid_r || out_ready);

  always_comb begin
    e_sum  = '0;
    len    = q_head.pos;
    len_w  = SUM_W'(len);
    s_base = trk_counting(st_cur) ? len : st_cur.anchor;
    e_base = trk_counting(en_cur) ? len : en_cur.anchor;
    s_sum  = SUM_W'(s_base) + SUM_W'(act_cur.start_char);
    s_cl   = (s_sum > len_w) ? len_w : s_sum;
    if (act_cur.end_open) begin
      e_cl = len_w;
    end else if (etake) begin
      e_sum = SUM_W'(e_base) + SUM_W'(act_cur.end_char);
      e_cl  = (e_sum > len_w) ? len_w : e_sum;
    end else begin
      e_cl = SUM_W'(e_base);
    end
    s_sat = (s_cl > SUM_W'(OUT_MAX));
    e_sat = (e_cl > SUM_W'(OUT_MAX));
    out_data_nxt.key_start = s_sat ? 16'hFFFF : s_cl[15:0];
    out_data_nxt.key_limit = e_sat ? 16'hFFFF : e_cl[15:0];
    out_data_nxt.too_long  = q_head.ovf || s_sat || e_sat;
  end

  always_comb begin
    act_nxt       = act_r;
    st_nxt        = st_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      act_nxt = act_cur;
      if (q_head.eol) begin
        st_nxt        = st_cur;
        en_nxt        = en_cur;
        out_valid_nxt = 1'b1;
      end else begin
        st_nxt = trk_step(st_cur, q_head, act_cur.start_skip_blanks, 1'b1);
        en_nxt = trk_step(en_cur, q_head, eskip, etake);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.eol) begin
      out_data_r <= out_data_nxt;
    end
    act_r <= act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      st_r        <= '{left: '0, phase: PH_OUT, anchor: '0};
      en_r        <= '{left: '0, phase: PH_OUT, anchor: '0};
    end else begin
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      en_r        <= en_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_st_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.phase) && $onehot(en_r.phase))
    else $error("tracker phase not one-hot");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_head.eol && !q_head.line_first && st_r.phase == PH_DONE)
      |=> st_r.phase == PH_DONE)
    else $error("start anchor moved after it was fixed");

  a_eol_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_head.eol && out_valid_r && !out_ready) |-> !q_pop)
    else $error("result overwritten before it was taken");

endmodule

// ===== hw/rtl/sort_key_field_locator.sv =====
// Sort-key field locator top level: configuration registers, front, queue, back.
// Depends on skfl_pkg, skfl_front, skfl_queue and skfl_back.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: data_byte[7:0]; tuser: func
//  out_     out  out_tvalid/out_tready tdata: key_start, key_limit, too_long
//  cfg_     in   cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// One request per cycle unless the queue is full; each result is held in a register.
// A four-entry queue decouples intake from the trackers; intake stalls only when full.
// An end-of-line request waits at the queue head while the output register is held.
// Reset is synchronous; configuration returns to blank-run splitting, key to line end.
module sort_key_field_locator
  import skfl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] key_start, [31:16] key_limit,
                                             // [32] too_long, [39:33] zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_wdata, q_head;
  res_t     res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SEPARATOR:   cfg_nxt.separator         = cfg_data[8:0];
        REG_START_FIELD: cfg_nxt.start_field       = cfg_data;
        REG_START_CHAR:  cfg_nxt.start_char        = cfg_data;
        REG_START_SKIP:  cfg_nxt.start_skip_blanks = cfg_data[0];
        REG_END_FIELD:   cfg_nxt.end_field         = cfg_data;
        REG_END_CHAR:    cfg_nxt.end_char          = cfg_data;
        REG_END_SKIP:    cfg_nxt.end_skip_blanks   = cfg_data[0];
        REG_END_OPEN:    cfg_nxt.end_open          = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{separator: 9'h100, start_field: '0, start_char: '0,
                 start_skip_blanks: 1'b0, end_field: '0, end_char: '0,
                 end_skip_blanks: 1'b0, end_open: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  skfl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser),
    .in_byte       (in_tdata),
    .cfg_separator (cfg_r.separator),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  skfl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  skfl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {7'b0, res.too_long, res.key_limit, res.key_start};

endmodule

// ===== tb/tb_sort_key_field_locator.sv =====
// Self-checking bench for sort_key_field_locator: streams lines, predicts key offsets.
// Depends on skfl_pkg and the sort_key_field_locator RTL with its front, queue and back.
`timescale 1ns / 100ps

module tb_sort_key_field_locator;
  import skfl_pkg::*;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } line_item_t;

  typedef struct packed {
    logic        too_long;
    logic [15:0] key_limit;
    logic [15:0] key_start;
  } key_span_t;

  typedef struct {
    logic [16:0]      left;
    phase_t           ph;
    logic [POS_W-1:0] anchor;
  } field_walk_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  sort_key_field_locator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  line_item_t       line_items_q[$];
  key_span_t        span_q[$];
  int unsigned      in_gap      = 0;
  int unsigned      out_gap     = 0;
  bit               in_fire     = 1'b0;
  bit               out_fire    = 1'b0;
  bit               in_idle_on  = 1'b1;
  bit               out_idle_on = 1'b1;
  int unsigned      n_err       = 0;
  int unsigned      n_results   = 0;
  int unsigned      n_lines     = 0;
  int unsigned      n_bytes     = 0;
  int unsigned      n_cfg       = 0;
  int unsigned      rand_items  = 0;

  // register mirror and per-line snapshot
  cfg_t             regs_m;
  cfg_t             line_m;
  logic             e_take, e_skip;
  logic [POS_W-1:0] pos_m;
  logic             ovf_m;
  field_walk_t      kst, ken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("TIMEOUT: stream did not drain");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic field_walk_t walk_load(logic [16:0] fields, logic skip);
    field_walk_t w;
    w.left   = fields;
    w.anchor = '0;
    if (fields != '0) begin
      w.ph = PH_OUT;
    end else begin
      w.ph = skip ? PH_SKIP : PH_DONE;
    end
    return w;
  endfunction

  function automatic logic walk_counting(field_walk_t w);
    return (w.ph == PH_OUT) || (w.ph == PH_IN);
  endfunction

  function automatic field_walk_t walk_byte(field_walk_t w, logic [7:0] b,
                                            logic [POS_W-1:0] p, logic [8:0] sep,
                                            logic skip, logic take_last);
    field_walk_t n;
    logic        blank;
    n     = w;
    blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A);
    if (walk_counting(n)) begin
      if (!sep[8]) begin
        if (b == sep[7:0]) begin
          n.left = n.left - 17'd1;
          if (n.left == '0) begin
            if (take_last) begin
              n.anchor = p + POS_W'(1);
              n.ph     = skip ? PH_SKIP : PH_DONE;
            end else begin
              n.anchor = p;
              n.ph     = PH_DONE;
            end
          end
        end
        return n;
      end
      if (!blank) begin
        n.ph = PH_IN;
        return n;
      end
      if (n.ph == PH_OUT) return n;
      n.ph   = PH_OUT;
      n.left = n.left - 17'd1;
      if (n.left != '0) return n;
      n.anchor = p;
      if (!skip) begin
        n.ph = PH_DONE;
        return n;
      end
      n.ph = PH_SKIP;
    end
    if (n.ph == PH_SKIP) begin
      if (blank) begin
        n.anchor = p + POS_W'(1);
      end else begin
        n.anchor = p;
        n.ph     = PH_DONE;
      end
    end
    return n;
  endfunction

  task automatic locate_step(logic func, logic [7:0] b);
    logic [SUM_W-1:0] s, e;
    logic             flag;
    key_span_t        r;
    if (pos_m == '0 && !ovf_m) begin
      line_m = regs_m;
      e_take = regs_m.end_char != '0;
      e_skip = regs_m.end_skip_blanks && e_take;
      kst    = walk_load({1'b0, regs_m.start_field}, regs_m.start_skip_blanks);
      ken    = walk_load({1'b0, regs_m.end_field} + 17'(!e_take), e_skip);
    end
    if (!func) begin
      if (pos_m == LINE_LIMIT) begin
        ovf_m = 1'b1;
      end else begin
        kst   = walk_byte(kst, b, pos_m, line_m.separator, line_m.start_skip_blanks, 1'b1);
        ken   = walk_byte(ken, b, pos_m, line_m.separator, e_skip, e_take);
        pos_m = pos_m + POS_W'(1);
      end
    end else begin
      s = walk_counting(kst) ? SUM_W'(pos_m) : SUM_W'(kst.anchor);
      s = s + SUM_W'(line_m.start_char);
      if (s > SUM_W'(pos_m)) s = SUM_W'(pos_m);
      if (line_m.end_open) begin
        e = SUM_W'(pos_m);
      end else begin
        e = walk_counting(ken) ? SUM_W'(pos_m) : SUM_W'(ken.anchor);
        if (e_take) begin
          e = e + SUM_W'(line_m.end_char);
          if (e > SUM_W'(pos_m)) e = SUM_W'(pos_m);
        end
      end
      flag = ovf_m;
      if (s > SUM_W'(OUT_MAX)) begin
        s    = SUM_W'(OUT_MAX);
        flag = 1'b1;
      end
      if (e > SUM_W'(OUT_MAX)) begin
        e    = SUM_W'(OUT_MAX);
        flag = 1'b1;
      end
      r.key_start = s[15:0];
      r.key_limit = e[15:0];
      r.too_long  = flag;
      span_q.push_back(r);
      pos_m = '0;
      ovf_m = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_err++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
  endtask

  // input side: requests change on the falling edge
  always @(negedge clk) begin
    line_item_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      in_fire = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (line_items_q.size() != 0) begin
        cur = line_items_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur.data;
        in_tuser  <= cur.func;
        in_gap = in_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_fire = 1'b1;
      locate_step(in_tuser, in_tdata);
    end
  end

  always @(negedge clk) begin
    if (out_fire) begin
      out_fire = 1'b0;
      out_gap  = out_idle_on ? $urandom_range(0, 10) : 0;
    end
    if (out_gap != 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    key_span_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_fire = 1'b1;
      n_results++;
      if (span_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[15:0], 0);
      end else begin
        want = span_q.pop_front();
        if (out_tdata[15:0] != want.key_start)
          report_mismatch("key_start", out_tdata[15:0], want.key_start);
        if (out_tdata[31:16] != want.key_limit)
          report_mismatch("key_limit", out_tdata[31:16], want.key_limit);
        if (out_tdata[32] != want.too_long)
          report_mismatch("too_long", out_tdata[32], want.too_long);
        if (out_tdata[39:33] != '0)
          report_mismatch("tdata padding", out_tdata[39:33], 0);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEPARATOR:   regs_m.separator         = val[8:0];
      REG_START_FIELD: regs_m.start_field       = val;
      REG_START_CHAR:  regs_m.start_char        = val;
      REG_START_SKIP:  regs_m.start_skip_blanks = val[0];
      REG_END_FIELD:   regs_m.end_field         = val;
      REG_END_CHAR:    regs_m.end_char          = val;
      REG_END_SKIP:    regs_m.end_skip_blanks   = val[0];
      REG_END_OPEN:    regs_m.end_open          = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the stream to empty, then let the pipeline settle
  task automatic drain();
    while (line_items_q.size() != 0 || in_tvalid || span_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_byte(logic [7:0] b);
    line_items_q.push_back('{func: 1'b0, data: b});
    n_bytes++;
  endtask

  task automatic push_eol();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    line_items_q.push_back('{func: 1'b1, data: junk});
    n_lines++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    push_eol();
  endtask

  task automatic push_blanks(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       push_byte(8'h20);
        1:       push_byte(8'h09);
        default: push_byte(8'h0A);
      endcase
    end
  endtask

  function automatic logic [7:0] word_byte(logic [7:0] sep);
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    b = 8'(33 + $urandom_range(0, 93));
    if (b == sep) b = (b == 8'h7E) ? 8'h21 : b + 8'd1;
    return b;
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      2:       return 16'd0;
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 5))
      0:       v[8:0] = {1'b1, 8'($urandom_range(0, 255))};
      1:       v[8:0] = 9'h02C;
      2:       v[8:0] = 9'h020;
      3:       v[8:0] = {1'b0, 8'($urandom_range(0, 255))};
      4:       v[8:0] = 9'h009;
      default: v[8:0] = 9'h1FF;
    endcase
    write_reg(REG_SEPARATOR, v);
    write_reg(REG_START_FIELD, pick_count());
    write_reg(REG_START_CHAR, pick_offset());
    write_reg(REG_START_SKIP, 16'($urandom));
    write_reg(REG_END_FIELD, pick_count());
    write_reg(REG_END_CHAR, pick_offset());
    write_reg(REG_END_SKIP, 16'($urandom));
    write_reg(REG_END_OPEN, 16'($urandom));
  endtask

  task automatic gen_line();
    int         nw, wl;
    logic [7:0] sep;
    logic       blank_mode;
    blank_mode = regs_m.separator[8];
    sep        = regs_m.separator[7:0];
    nw         = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) push_blanks($urandom_range(1, 2));
    for (int i = 0; i < nw; i++) begin
      wl = $urandom_range(0, 4);
      for (int j = 0; j < wl; j++) push_byte(word_byte(sep));
      if (i != nw - 1 || $urandom_range(0, 3) == 0) begin
        if (blank_mode) begin
          push_blanks($urandom_range(1, 3));
        end else begin
          if ($urandom_range(0, 2) == 0) push_blanks(1);
          push_byte(sep);
          if ($urandom_range(0, 2) == 0) push_blanks($urandom_range(1, 2));
        end
      end
    end
    push_eol();
  endtask

  task automatic long_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(($urandom_range(0, 7) == 0) ? 8'h20 : 8'($urandom_range(8'h61, 8'h7A)));
    end
    push_eol();
  endtask

  initial begin
    int unsigned rand_lines;
    int unsigned nl;
    regs_m                   = '0;
    regs_m.separator         = 9'h100;
    regs_m.end_open          = 1'b1;
    pos_m                    = '0;
    ovf_m                    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: blank runs, key is the whole line; empty line first
    push_eol();
    push_text(" ab\tc");
    drain();

    // colon fields, start after first field plus one byte, end on closing colon
    write_reg(REG_SEPARATOR, 16'h003A);
    write_reg(REG_START_FIELD, 16'd1);
    write_reg(REG_START_CHAR, 16'd1);
    write_reg(REG_END_FIELD, 16'd1);
    write_reg(REG_END_CHAR, 16'd0);
    write_reg(REG_END_OPEN, 16'd0);
    push_text("ab:cde:f");
    drain();

    // blank runs with blank skipping on both ends
    write_reg(REG_SEPARATOR, 16'h0100);
    write_reg(REG_START_CHAR, 16'd0);
    write_reg(REG_START_SKIP, 16'd1);
    write_reg(REG_END_CHAR, 16'd2);
    write_reg(REG_END_SKIP, 16'd1);
    push_text("x \t yz");
    drain();

    // start field beyond the line
    write_reg(REG_START_FIELD, 16'd7);
    push_text("a b");
    drain();

    // lines at and past the length limit, no idling
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_reg(REG_START_FIELD, 16'd2);
    write_reg(REG_START_CHAR, 16'd3);
    write_reg(REG_END_FIELD, 16'd500);
    write_reg(REG_END_CHAR, 16'd0);
    long_line(LINE_LIMIT);
    long_line(LINE_LIMIT + 2);
    drain();

    rand_lines = 0;
    while (rand_items < 600 || rand_lines < 50) begin
      drain();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      random_config();
      nl = $urandom_range(3, 8);
      for (int unsigned k = 0; k < nl; k++) begin
        rand_items = rand_items - line_items_q.size();
        gen_line();
        rand_items = rand_items + line_items_q.size();
        rand_lines++;
        if ($urandom_range(0, 5) == 0) drain();
      end
    end
    drain();

    $display("Run covered %0d lines, %0d content bytes, %0d register writes,",
             n_lines, n_bytes, n_cfg);
    $display("including empty, unreached-field and over-limit lines; %0d results checked.",
             n_results);
    if (span_q.size() != 0) report_mismatch("results never produced", 0, span_q.size());
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
